>>> src/tscs_pkg.sv
// Shared types and constants of the slope-cone trajectory simplifier.
package tscs_pkg;

  localparam int SLOPE_W   = 48;
  localparam int RES_W     = 64;
  localparam int TOL_W     = 16;
  localparam int IDX_W     = 16;
  localparam int GROUP_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = 48'sh8000_0000_0001;
  localparam logic [RES_W-1:0]          BIG_MAG   = 64'h4000_0000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL = 2'd1;

  typedef struct packed {
    logic               seg_kind;
    logic signed [31:0] time_value;
    logic signed [31:0] distance_value;
    logic [15:0]        group_id;
    logic               last_segment;
  } tscs_in_t;

  typedef struct packed {
    logic [15:0] key_index;
    logic        end_of_run;
  } tscs_out_t;

  typedef struct packed {
    logic start;
    logic is_mul;
    logic sat_big;
  } mdu_ctl_t;

endpackage

>>> src/tscs_mdu.sv
// Bit-serial multiply/divide unit with one shared adder and saturating result.
module tscs_mdu #(
  parameter int AW = 33,
  parameter int BW = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tscs_pkg::mdu_ctl_t                  ctl,
  input  logic signed [AW-1:0]                op_a,
  input  logic signed [BW-1:0]                op_b,
  output logic                                done,
  output logic signed [tscs_pkg::RES_W-1:0]   res
);
  import tscs_pkg::*;

  localparam int DVW   = AW + 16;
  localparam int PW    = AW + BW;
  localparam int MW    = (PW > RES_W) ? PW : RES_W;
  localparam int CNT_W = $clog2(DVW + 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVW - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(AW - 1);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t              state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 is_mul_r, big_r, neg_r, zden_r, azero_r, done_r;
  logic [BW-1:0]        mb_r;
  logic [BW-1:0]        acc_r;
  logic [DVW-1:0]       sh_r;
  logic signed [RES_W-1:0] res_r;

  logic [AW-1:0]  ma;
  logic [BW-1:0]  mb;
  logic [BW:0]    add_x, add_y;
  logic           add_ci;
  logic [BW+1:0]  add_s;
  logic           qbit;
  logic [MW-1:0]  mag_full, mag_max;
  logic [RES_W-1:0] mag_sat;

  assign ma = op_a[AW-1] ? (~op_a + AW'(1)) : op_a;
  assign mb = op_b[BW-1] ? (~op_b + BW'(1)) : op_b;

  // one adder: trial subtract for the quotient, add for the product
  always_comb begin
    if (is_mul_r) begin
      add_x  = {1'b0, acc_r};
      add_y  = sh_r[0] ? {1'b0, mb_r} : '0;
      add_ci = 1'b0;
    end else begin
      add_x  = {acc_r, sh_r[DVW-1]};
      add_y  = ~{1'b0, mb_r};
      add_ci = 1'b1;
    end
    add_s = {1'b0, add_x} + {1'b0, add_y} + {{(BW+1){1'b0}}, add_ci};
    qbit  = add_s[BW+1];
  end

  always_comb begin
    mag_max = big_r ? MW'(BIG_MAG) : MW'(SLOPE_MAX);
    if (is_mul_r) begin
      mag_full = MW'({acc_r, sh_r[AW-1:0]} >> 16);
    end else begin
      mag_full = MW'(sh_r);
    end
    if (zden_r) begin
      mag_sat = azero_r ? '0 : RES_W'(mag_max);
    end else if (mag_full > mag_max) begin
      mag_sat = RES_W'(mag_max);
    end else begin
      mag_sat = RES_W'(mag_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        M_IDLE: begin
          done_r <= 1'b0;
          if (ctl.start) begin
            is_mul_r <= ctl.is_mul;
            big_r    <= ctl.sat_big;
            neg_r    <= op_a[AW-1] ^ op_b[BW-1];
            azero_r  <= (op_a == '0);
            zden_r   <= !ctl.is_mul && (op_b == '0);
            mb_r     <= mb;
            acc_r    <= '0;
            cnt_r    <= '0;
            if (ctl.is_mul) begin
              sh_r <= DVW'(ma);
            end else begin
              sh_r <= {ma, 16'h0000};
            end
            state_r <= (!ctl.is_mul && (op_b == '0)) ? M_FIN : M_RUN;
          end
        end
        M_RUN: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (is_mul_r) begin
            acc_r <= add_s[BW:1];
            sh_r  <= {sh_r[DVW-1:AW], add_s[0], sh_r[AW-1:1]};
            if (cnt_r == MUL_LAST) state_r <= M_FIN;
          end else begin
            acc_r <= qbit ? add_s[BW-1:0] : add_x[BW-1:0];
            sh_r  <= {sh_r[DVW-2:0], qbit};
            if (cnt_r == DIV_LAST) state_r <= M_FIN;
          end
        end
        M_FIN: begin
          res_r   <= neg_r ? (RES_W'(0) - mag_sat) : mag_sat;
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: begin
          state_r <= M_IDLE;
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> src/tscs_oq.sv
// Two-word result queue between the sequencer and the output channel.
module tscs_oq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tscs_pkg::tscs_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output tscs_pkg::tscs_out_t out_data
);
  import tscs_pkg::*;

  tscs_out_t  head_r, tail_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (pop) begin
        head_r <= (push && cnt_r == 2'd1) ? push_data : tail_r;
        if (push && cnt_r == 2'd2) tail_r <= push_data;
      end else if (push) begin
        if (cnt_r == 2'd0) begin
          head_r <= push_data;
        end else begin
          tail_r <= push_data;
        end
      end
    end
  end

endmodule

>>> src/trajectory_slope_cone_simplifier.sv
// Slope-cone trajectory simplifier: sequencer, cone state and shared arithmetic unit.
// One item at a time; in_stall is high from acceptance until the item is finished.
// An item that opens a group or run may wait for room in the result queue.
// A cone test runs up to two serial quotients of COORD_WIDTH+17 steps each; a cone
// break adds two clip steps through the same unit and a second cone test.
// Reset (rst_n low, synchronous) clears counters, cone state and the result queue.
module trajectory_slope_cone_simplifier #(
  parameter int MAX_SEGMENTS = 65536,
  parameter int COORD_WIDTH  = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tscs_pkg::tscs_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tscs_pkg::tscs_out_t                   out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tscs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tscs_pkg::TOL_W-1:0]            cfg_data
);
  import tscs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = CW + 1;
  localparam int BW   = (CW + 1 > SLOPE_W) ? CW + 1 : SLOPE_W;
  localparam int GW   = 66;
  localparam int CNTW = $clog2(MAX_SEGMENTS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(MAX_SEGMENTS - 1);
  localparam logic signed [GW-1:0] CMAX = {{(GW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [GW-1:0] CMIN = {{(GW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_GPUSHP, S_GPUSHI, S_SLOPE, S_SWAIT, S_TEST,
    S_BPUSH, S_CLIP, S_CWAIT, S_CFIN, S_LPUSH, S_FIN
  } state_t;

  function automatic logic signed [CW-1:0] sat_c(input logic signed [GW-1:0] v);
    if (v > CMAX) return CMAX[CW-1:0];
    else if (v < CMIN) return CMIN[CW-1:0];
    else return v[CW-1:0];
  endfunction

  function automatic logic signed [GW-1:0] sx(input logic signed [CW-1:0] v);
    return {{(GW-CW){v[CW-1]}}, v};
  endfunction

  state_t                state_r;
  tscs_in_t              in_r;
  logic [TOL_W-1:0]      time_tol_r, dist_tol_r;
  logic [CNTW-1:0]       cnt_r, base_idx_r;
  logic [GROUP_W-1:0]    base_group_r;
  logic                  base_kind_r, prev_kind_r, sel_r, clipped_r;
  logic signed [CW-1:0]  cx1_r, cx2_r, cy1_r, cy2_r;
  logic signed [CW-1:0]  bx1_r, bx2_r, by1_r, by2_r;
  logic signed [CW-1:0]  px1_r, px2_r, py1_r, py2_r;
  logic signed [CW-1:0]  vr0_r, vr1_r, hi_r;
  logic signed [SLOPE_W-1:0] upper_r, lower_r, ub_r;
  logic signed [SLOPE_W-1:0] lb_q;
  logic signed [CW-1:0]      hi_q, lo_q;

  // corners of the incoming segment
  logic signed [CW-1:0] tc, dc, ncx1, ncx2, ncy1, ncy2;
  logic signed [GW-1:0] ttol, dtol;
  always_comb begin
    tc   = sat_c({{(GW-32){in_r.time_value[31]}}, in_r.time_value});
    dc   = sat_c({{(GW-32){in_r.distance_value[31]}}, in_r.distance_value});
    ttol = {{(GW-TOL_W-8){1'b0}}, time_tol_r, 8'h00};
    dtol = {{(GW-TOL_W-8){1'b0}}, dist_tol_r, 8'h00};
    if (!in_r.seg_kind) begin
      ncx1 = sat_c(sx(tc) - ttol);
      ncx2 = sat_c(sx(tc) + ttol);
      ncy1 = dc;
      ncy2 = dc;
    end else begin
      ncy1 = sat_c(sx(dc) - dtol);
      ncy2 = sat_c(sx(dc) + dtol);
      ncx1 = tc;
      ncx2 = tc;
    end
  end

  // cone apex points: upper through (ax_u, ay_u), lower through (ax_l, ay_l)
  logic signed [CW-1:0] ax_u, ay_u, ax_l, ay_l, ax, ay, tx, ty;
  logic signed [AW-1:0] dx, dy, clip_a;
  logic signed [SLOPE_W-1:0] clip_k;
  always_comb begin
    ax_u = base_kind_r ? bx1_r : vr1_r;
    ay_u = base_kind_r ? vr0_r : by2_r;
    ax_l = base_kind_r ? bx2_r : vr0_r;
    ay_l = base_kind_r ? vr1_r : by1_r;
    ax   = sel_r ? ax_l : ax_u;
    ay   = sel_r ? ay_l : ay_u;
    tx   = (sel_r ^ in_r.seg_kind) ? cx2_r : cx1_r;
    ty   = (sel_r ^ in_r.seg_kind) ? cy2_r : cy1_r;
    dx   = AW'(sx(tx) - sx(ax));
    dy   = AW'(sx(ty) - sx(ay));
    clip_a = prev_kind_r ? AW'(sx(px1_r) - sx(ax)) : AW'(sx(py1_r) - sx(ay));
    clip_k = sel_r ? lower_r : upper_r;
  end

  mdu_ctl_t                mdu_ctl;
  logic signed [AW-1:0]    mdu_a;
  logic signed [BW-1:0]    mdu_b;
  logic                    mdu_done;
  logic signed [RES_W-1:0] mdu_res;

  always_comb begin
    mdu_ctl.start   = (state_r == S_CLIP) || ((state_r == S_SLOPE) && (dx != '0));
    mdu_ctl.is_mul  = (state_r == S_CLIP) && prev_kind_r;
    mdu_ctl.sat_big = (state_r == S_CLIP);
    if (state_r == S_CLIP) begin
      mdu_a = clip_a;
      mdu_b = {{(BW-SLOPE_W){clip_k[SLOPE_W-1]}}, clip_k};
    end else begin
      mdu_a = dy;
      mdu_b = {{(BW-AW){dx[AW-1]}}, dx};
    end
  end

  tscs_mdu #(.AW(AW), .BW(BW)) u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mdu_ctl),
    .op_a  (mdu_a),
    .op_b  (mdu_b),
    .done  (mdu_done),
    .res   (mdu_res)
  );

  // clipped end: anchor plus offset, saturated
  logic signed [CW-1:0] clip_v, sw_hi, sw_lo, p_lo, p_hi;
  always_comb begin
    clip_v = sat_c(sx(prev_kind_r ? ay : ax) + {{(GW-RES_W){mdu_res[RES_W-1]}}, mdu_res});
    sw_hi  = (hi_r < clip_v) ? clip_v : hi_r;
    sw_lo  = (hi_r < clip_v) ? hi_r : clip_v;
    p_lo   = prev_kind_r ? py1_r : px1_r;
    p_hi   = prev_kind_r ? py2_r : px2_r;
  end

  logic            oq_push, oq_full, new_group;
  tscs_out_t       oq_word;
  logic [CNTW-1:0] pidx;

  assign pidx      = cnt_r - CNTW'(1);
  assign new_group = (cnt_r == '0) || (in_r.group_id != base_group_r);
  assign oq_push   = !oq_full && (state_r == S_GPUSHP || state_r == S_GPUSHI ||
                                  state_r == S_BPUSH  || state_r == S_LPUSH);
  always_comb begin
    if (state_r == S_GPUSHP || state_r == S_BPUSH) begin
      oq_word.key_index  = IDX_W'(pidx);
      oq_word.end_of_run = 1'b0;
    end else begin
      oq_word.key_index  = IDX_W'(cnt_r);
      oq_word.end_of_run = in_r.last_segment;
    end
  end

  tscs_oq u_oq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_word),
    .full      (oq_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      time_tol_r   <= '0;
      dist_tol_r   <= '0;
      cnt_r        <= '0;
      base_idx_r   <= '0;
      base_group_r <= '0;
      base_kind_r  <= 1'b0;
      prev_kind_r  <= 1'b0;
      sel_r        <= 1'b0;
      clipped_r    <= 1'b0;
      bx1_r <= '0; bx2_r <= '0; by1_r <= '0; by2_r <= '0;
      px1_r <= '0; px2_r <= '0; py1_r <= '0; py2_r <= '0;
      vr0_r <= '0; vr1_r <= '0;
      upper_r <= SLOPE_MAX;
      lower_r <= SLOPE_MIN;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TIME_TOL: time_tol_r <= cfg_data;
          REG_DIST_TOL: dist_tol_r <= cfg_data;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          cx1_r <= ncx1; cx2_r <= ncx2; cy1_r <= ncy1; cy2_r <= ncy2;
          sel_r     <= 1'b0;
          clipped_r <= 1'b0;
          if (new_group) begin
            base_group_r <= in_r.group_id;
            vr0_r <= in_r.seg_kind ? ncy1 : ncx1;
            vr1_r <= in_r.seg_kind ? ncy2 : ncx2;
            bx1_r <= ncx1; bx2_r <= ncx2; by1_r <= ncy1; by2_r <= ncy2;
            base_kind_r <= in_r.seg_kind;
            base_idx_r  <= cnt_r;
            upper_r     <= SLOPE_MAX;
            lower_r     <= SLOPE_MIN;
            state_r <= (cnt_r != '0 && pidx != base_idx_r) ? S_GPUSHP : S_GPUSHI;
          end else begin
            state_r <= S_SLOPE;
          end
        end
        S_GPUSHP: if (!oq_full) state_r <= S_GPUSHI;
        S_GPUSHI: if (!oq_full) state_r <= S_FIN;
        S_SLOPE: begin
          if (dx == '0) begin
            // vertical step: slope is zero, skip the unit
            if (!sel_r) begin
              ub_r  <= '0;
              sel_r <= 1'b1;
            end else begin
              lower_r <= lower_r;
              ub_r    <= ub_r;
              hi_r    <= hi_r;
              state_r <= S_TEST;
            end
          end else begin
            state_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (mdu_done) begin
            if (!sel_r) begin
              ub_r    <= mdu_res[SLOPE_W-1:0];
              sel_r   <= 1'b1;
              state_r <= S_SLOPE;
            end else begin
              state_r <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (!clipped_r && (ub_r < lower_r || lb_q > upper_r)) begin
            state_r <= S_BPUSH;
          end else if (in_r.last_segment) begin
            state_r <= S_LPUSH;
          end else begin
            if (ub_r < upper_r) upper_r <= ub_r;
            if (lb_q > lower_r) lower_r <= lb_q;
            state_r <= S_FIN;
          end
        end
        S_BPUSH: begin
          if (!oq_full) begin
            sel_r   <= 1'b0;
            state_r <= S_CLIP;
          end
        end
        S_CLIP: state_r <= S_CWAIT;
        S_CWAIT: begin
          if (mdu_done) begin
            if (!sel_r) begin
              hi_r    <= clip_v;
              sel_r   <= 1'b1;
              state_r <= S_CLIP;
            end else begin
              state_r <= S_CFIN;
            end
          end
        end
        S_CFIN: begin
          // previous segment, clipped to the cone, becomes the base
          vr0_r <= (lo_q > p_lo) ? lo_q : p_lo;
          vr1_r <= (hi_q < p_hi) ? hi_q : p_hi;
          bx1_r <= px1_r; bx2_r <= px2_r; by1_r <= py1_r; by2_r <= py2_r;
          base_kind_r <= prev_kind_r;
          base_idx_r  <= pidx;
          upper_r     <= SLOPE_MAX;
          lower_r     <= SLOPE_MIN;
          clipped_r   <= 1'b1;
          sel_r       <= 1'b0;
          state_r     <= S_SLOPE;
        end
        S_LPUSH: if (!oq_full) state_r <= S_FIN;
        S_FIN: begin
          px1_r <= cx1_r; px2_r <= cx2_r; py1_r <= cy1_r; py2_r <= cy2_r;
          prev_kind_r <= in_r.seg_kind;
          if (in_r.last_segment || cnt_r == CNT_LAST) begin
            cnt_r <= '0;
          end else begin
            cnt_r <= cnt_r + CNTW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // lower bound and clipped ends held separately from the sequencer block
  always_ff @(posedge clk) begin
    if (state_r == S_SLOPE && dx == '0 && sel_r) lb_q <= '0;
    if (state_r == S_SWAIT && mdu_done && sel_r) lb_q <= mdu_res[SLOPE_W-1:0];
    if (state_r == S_CWAIT && mdu_done && sel_r) begin
      hi_q <= sw_hi;
      lo_q <= sw_lo;
    end
  end

  a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_done |-> (state_r == S_SWAIT || state_r == S_CWAIT))
    else $error("arithmetic unit finished while sequencer was not waiting");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_PREP))
    else $error("accepted word did not start preparation");

  a_rebase_resets_cone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CFIN) |=> (upper_r == SLOPE_MAX && lower_r == SLOPE_MIN && clipped_r))
    else $error("rebase did not reopen the cone");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && in_r.last_segment) |=> (cnt_r == '0))
    else $error("segment counter not cleared after last segment");

endmodule

>>> tb/sv/tb.sv
// Testbench for the slope-cone trajectory simplifier: directed and random trajectories.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tscs_pkg::*;

  localparam int       SEG_COUNT  = 65536;
  localparam int       DRAIN_CYC  = 300;
  localparam longint   CYCLE_CAP  = 4000000;
  localparam longint   CONE_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint   CLIP_MAX   = 64'sh4000_0000_0000_0000;
  localparam int       TLO = 0, THI = 1, DLO = 2, DHI = 3;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  tscs_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tscs_out_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TOL_W-1:0]     cfg_data = '0;

  trajectory_slope_cone_simplifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cone predictor state
  int     tol_time, tol_dist;
  int     seg_count, anchor_kind, anchor_index, anchor_group, last_kind;
  longint anchor_c[4], last_c[4], window[2];
  longint cone_hi, cone_lo;

  tscs_out_t key_q[$];
  int        mismatches = 0;
  bit        jitter_on = 1'b1;
  longint    cycles = 0;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned umag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // num * 2^16 / den, truncated toward zero, saturated to +-lim
  function automatic longint frac_div(longint num, longint den, longint lim);
    longint unsigned n, d, q, r;
    bit neg;
    neg = (num < 0) != (den < 0);
    if (den == 0) return num > 0 ? lim : (num < 0 ? -lim : 0);
    n = umag(num);
    d = umag(den);
    q = n / d;
    r = n % d;
    if (q > (longint'(lim) >>> 16)) q = lim;
    else begin
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      if (q > lim) q = lim;
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint slope_times(longint k, longint dx);
    longint unsigned a, b, bh, bl, p, big;
    bit neg;
    big = CLIP_MAX;
    a = umag(k);
    b = umag(dx);
    bh = b >> 16;
    bl = b & 64'hFFFF;
    neg = (k < 0) != (dx < 0);
    if (bh != 0 && a > big / bh) p = big;
    else begin
      p = a * bh + ((a * bl) >> 16);
      if (p > big) p = big;
    end
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint slope(longint x1, longint y1, longint x2, longint y2);
    if (x2 == x1) return 0;
    return frac_div(y2 - y1, x2 - x1, CONE_MAX);
  endfunction

  function automatic void cone_bounds(longint c[4], int kind, output longint ub,
                                      output longint lb);
    if (anchor_kind == 1) begin
      if (kind == 0) begin
        ub = slope(anchor_c[TLO], window[0], c[TLO], c[DLO]);
        lb = slope(anchor_c[THI], window[1], c[THI], c[DHI]);
      end else begin
        ub = slope(anchor_c[TLO], window[0], c[THI], c[DHI]);
        lb = slope(anchor_c[THI], window[1], c[TLO], c[DLO]);
      end
    end else begin
      if (kind == 0) begin
        ub = slope(window[1], anchor_c[DHI], c[TLO], c[DLO]);
        lb = slope(window[0], anchor_c[DLO], c[THI], c[DHI]);
      end else begin
        ub = slope(window[1], anchor_c[DHI], c[THI], c[DHI]);
        lb = slope(window[0], anchor_c[DLO], c[TLO], c[DLO]);
      end
    end
  endfunction

  function automatic void new_anchor(longint c[4], int kind, int index);
    anchor_c = c;
    anchor_kind = kind;
    anchor_index = index;
    cone_hi = CONE_MAX;
    cone_lo = -CONE_MAX;
  endfunction

  // Clip the previous segment to the cone and make it the anchor
  function automatic void clip_to_cone(int pidx);
    longint ux, uy, lx, ly, hi, lo, t;
    if (anchor_kind == 1) begin
      ux = anchor_c[TLO]; uy = window[0]; lx = anchor_c[THI]; ly = window[1];
    end else begin
      ux = window[1]; uy = anchor_c[DHI]; lx = window[0]; ly = anchor_c[DLO];
    end
    if (last_kind == 0) begin
      hi = clamp32(ux + frac_div(last_c[DLO] - uy, cone_hi, CLIP_MAX));
      lo = clamp32(lx + frac_div(last_c[DLO] - ly, cone_lo, CLIP_MAX));
      if (hi < lo) begin t = hi; hi = lo; lo = t; end
      window[0] = lo > last_c[TLO] ? lo : last_c[TLO];
      window[1] = hi < last_c[THI] ? hi : last_c[THI];
    end else begin
      hi = clamp32(uy + slope_times(cone_hi, last_c[TLO] - ux));
      lo = clamp32(ly + slope_times(cone_lo, last_c[TLO] - lx));
      if (hi < lo) begin t = hi; hi = lo; lo = t; end
      window[0] = lo > last_c[DLO] ? lo : last_c[DLO];
      window[1] = hi < last_c[DHI] ? hi : last_c[DHI];
    end
    new_anchor(last_c, last_kind, pidx);
  endfunction

  function automatic void push_key(int index);
    tscs_out_t r;
    r.key_index = index[15:0];
    r.end_of_run = 1'b0;
    key_q.insert(key_q.size(), r);
  endfunction

  function automatic void cone_step(tscs_in_t it);
    longint t, d, ub, lb;
    longint c[4];
    int kind, idx, pidx, n0;
    kind = it.seg_kind;
    t = longint'($signed(it.time_value));
    d = longint'($signed(it.distance_value));
    idx = seg_count;
    pidx = (idx + SEG_COUNT - 1) % SEG_COUNT;
    n0 = key_q.size();
    if (kind == 0) begin
      c[TLO] = clamp32(t - (longint'(tol_time) << 8));
      c[THI] = clamp32(t + (longint'(tol_time) << 8));
      c[DLO] = d; c[DHI] = d;
    end else begin
      c[DLO] = clamp32(d - (longint'(tol_dist) << 8));
      c[DHI] = clamp32(d + (longint'(tol_dist) << 8));
      c[TLO] = t; c[THI] = t;
    end
    if (idx == 0 || int'(it.group_id) != anchor_group) begin
      if (idx == 0) push_key(0);
      else begin
        if (pidx != anchor_index) push_key(pidx);
        push_key(idx);
      end
      anchor_group = it.group_id;
      window[0] = kind == 0 ? c[TLO] : c[DLO];
      window[1] = kind == 0 ? c[THI] : c[DHI];
      new_anchor(c, kind, idx);
    end else begin
      cone_bounds(c, kind, ub, lb);
      if (ub < cone_lo || lb > cone_hi) begin
        push_key(pidx);
        clip_to_cone(pidx);
        cone_bounds(c, kind, ub, lb);
      end
      if (it.last_segment) push_key(idx);
      else begin
        if (ub < cone_hi) cone_hi = ub;
        if (lb > cone_lo) cone_lo = lb;
      end
    end
    last_c = c;
    last_kind = kind;
    if (it.last_segment) begin
      if (key_q.size() > n0) key_q[key_q.size()-1].end_of_run = 1'b1;
      seg_count = 0;
    end else seg_count = (idx + 1) % SEG_COUNT;
  endfunction

  function automatic void cone_reset();
    longint z[4];
    z = '{0, 0, 0, 0};
    tol_time = 0; tol_dist = 0;
    seg_count = 0; anchor_group = 0; last_kind = 0;
    last_c = z;
    window = '{0, 0};
    new_anchor(z, 0, 0);
  endfunction

  // Result check
  always @(posedge clk) begin
    tscs_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (key_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word key_index=%0d end_of_run=%0b", $time,
                 out_data.key_index, out_data.end_of_run);
      end else begin
        want = key_q.pop_front();
        if (out_data.key_index !== want.key_index) begin
          mismatches++;
          $display("%0t: key_index expected %0d actual %0d", $time, want.key_index,
                   out_data.key_index);
        end
        if (out_data.end_of_run !== want.end_of_run) begin
          mismatches++;
          $display("%0t: end_of_run expected %0b actual %0b", $time, want.end_of_run,
                   out_data.end_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= jitter_on && ($urandom_range(0, 99) < 15);
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(tscs_in_t it);
    if (jitter_on && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    cone_step(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (key_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TIME_TOL) tol_time = val[15:0];
    else tol_dist = val[15:0];
  endtask

  function automatic tscs_in_t mk(bit kind, int t, int d, int g, bit last);
    tscs_in_t it;
    it.seg_kind = kind;
    it.time_value = t;
    it.distance_value = d;
    it.group_id = g[15:0];
    it.last_segment = last;
    return it;
  endfunction

  // Well-formed run: time mostly rising, distance drifting, with jumps to break the cone
  task automatic run_trajectory(int len, int g);
    int t, d, v;
    t = $urandom_range(0, 1 << 24) - (1 << 23);
    d = $urandom_range(0, 1 << 24) - (1 << 23);
    v = $urandom_range(0, 2000);
    for (int i = 0; i < len; i++) begin
      t += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4000);
      if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 4000) - 1000;
      d += v + $urandom_range(0, 600) - 300;
      if ($urandom_range(0, 30) == 0) g = $urandom_range(0, 65535);
      send_item(mk(1'($urandom_range(0, 1)), t, d, g, i == len - 1));
    end
  endtask

  task automatic test_extremes();
    send_item(mk(0, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_item(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0));
    send_item(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    send_item(mk(1, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 0));
    send_item(mk(1, 32'h8000_0000, 0, 16'hFFFF, 1));
    write_reg(REG_TIME_TOL, 65535);
    write_reg(REG_DIST_TOL, 65535);
    send_item(mk(0, 32'h7FFF_0000, 32'h7FFF_FFFF, 7, 0));
    send_item(mk(1, 32'h8000_1000, 32'h8000_0000, 7, 0));
    send_item(mk(0, 32'h7FFF_FFFF, 32'h8000_0000, 7, 0));
    send_item(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7, 1));
    send_item(mk(0, 100, 200, 3, 1));
  endtask

  task automatic test_zero_step_and_break();
    write_reg(REG_TIME_TOL, 0);
    write_reg(REG_DIST_TOL, 0);
    // same time repeated: zero time step
    send_item(mk(0, 1000, 0, 5, 0));
    send_item(mk(1, 1000, 500, 5, 0));
    send_item(mk(0, 1000, 900, 5, 0));
    // zigzag: empty cone, clip through zero slopes
    send_item(mk(0, 2000, 0, 5, 0));
    send_item(mk(1, 3000, 5000, 5, 0));
    send_item(mk(0, 4000, -5000, 5, 0));
    send_item(mk(1, 5000, 9000, 5, 0));
    send_item(mk(0, 6000, 9000, 9, 0));
    send_item(mk(1, 7000, -9000, 9, 1));
  endtask

  task automatic test_random();
    int sets[5][2];
    sets = '{'{0, 0}, '{65535, 65535}, '{3, 1}, '{0, 40}, '{20, 0}};
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_TIME_TOL, sets[p][0]);
      write_reg(REG_DIST_TOL, sets[p][1]);
      jitter_on = (p != 2);
      for (int n = 0; n < 222; ) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(mk(1'($urandom), int'($urandom), int'($urandom), int'($urandom),
                       $urandom_range(0, 3) == 0));
          n++;
        end else begin
          int len;
          len = $urandom_range(1, 20);
          run_trajectory(len, $urandom_range(0, 3));
          n += len;
        end
      end
      send_item(mk(0, 0, 0, 0, 1));
    end
    jitter_on = 1'b1;
  endtask

  initial begin
    cone_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_step_and_break();
    test_random();
    drain();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> files.f
src/tscs_pkg.sv
src/tscs_mdu.sv
src/tscs_oq.sv
src/trajectory_slope_cone_simplifier.sv
tb/sv/tb.sv
